// File: rtl/sip_pkg.sv
// Shared types, widths and codes of the split interval pruner.
package sip_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    // Field widths
    localparam int POS_W  = 20;
    localparam int SC_W   = 17;
    localparam int GAP_W  = 16;
    localparam int CNT_W  = 11;
    localparam int BEST_W = 17;
    localparam int SG_W   = 18;
    localparam int IX_W   = 13;   // signed index arithmetic
    localparam int VW     = 23;   // signed position and score arithmetic
    localparam int CFG_W  = 16;

    typedef logic signed [IX_W-1:0] ix_t;
    typedef logic signed [VW-1:0]   val_t;

    // Command codes
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_RECORD = 3'd1;
    localparam logic [2:0] CMD_TEST   = 3'd2;
    localparam logic [2:0] CMD_SHRINK = 3'd3;
    localparam logic [2:0] CMD_NEIGH  = 3'd4;

    // Register indexes
    localparam logic REG_GAP_ALLOWANCE  = 1'b0;
    localparam logic REG_POSITION_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]               command;
        logic [9:0]               entry_index;
        logic [POS_W-1:0]         position_value;
        logic signed [SC_W-1:0]   left_score_in;
        logic signed [SC_W-1:0]   right_score_in;
        logic [10:0]              bound_left;
        logic signed [10:0]       bound_right;
        logic signed [10:0]       last_left_split;
        logic signed [10:0]       last_right_split;
        logic [BEST_W-1:0]        best_score;
        logic signed [SG_W-1:0]   score_gap;
    } item_t;

    typedef struct packed {
        logic                keep_interval;
        logic [10:0]         new_left;
        logic signed [11:0]  new_right;
        logic signed [10:0]  new_last_left;
        logic signed [10:0]  new_last_right;
    } res_t;

endpackage

// File: rtl/sip_tables.sv
// Position table and score record memories with one shared address port.
module sip_tables #(
    parameter int TABLE_DEPTH = sip_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   addr,
    input  logic                             pos_we,
    input  logic [sip_pkg::POS_W-1:0]        pos_wdata,
    input  logic                             sc_we,
    input  logic [2*sip_pkg::SC_W-1:0]       sc_wdata,
    output logic [sip_pkg::POS_W-1:0]        pos_rdata,
    output logic [2*sip_pkg::SC_W-1:0]       sc_rdata
);
    import sip_pkg::*;

    logic [POS_W-1:0]  pos_mem [TABLE_DEPTH];
    logic [2*SC_W-1:0] sc_mem  [TABLE_DEPTH];
    logic [POS_W-1:0]  pos_rdata_reg;
    logic [2*SC_W-1:0] sc_rdata_reg;

    // Write and registered read of the position table
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[addr] <= pos_wdata;
        end
        pos_rdata_reg <= pos_mem[addr];
    end

    // Write and registered read of the score record
    always_ff @(posedge aclk) begin
        if (sc_we) begin
            sc_mem[addr] <= sc_wdata;
        end
        sc_rdata_reg <= sc_mem[addr];
    end

    assign pos_rdata = pos_rdata_reg;
    assign sc_rdata  = sc_rdata_reg;

endmodule

// File: rtl/sip_ctrl.sv
// Sequencer, markers, configuration and shared search datapath.
module sip_ctrl #(
    parameter int TABLE_DEPTH = sip_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sip_pkg::item_t                   in_item,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [sip_pkg::CFG_W-1:0]        cfg_wdata,
    output logic                             res_valid,
    input  logic                             res_ready,
    output sip_pkg::res_t                    res,
    output logic [$clog2(TABLE_DEPTH)-1:0]   mem_addr,
    output logic                             pos_we,
    output logic [sip_pkg::POS_W-1:0]        pos_wdata,
    output logic                             sc_we,
    output logic [2*sip_pkg::SC_W-1:0]       sc_wdata,
    input  logic [sip_pkg::POS_W-1:0]        pos_rdata,
    input  logic [2*sip_pkg::SC_W-1:0]       sc_rdata
);
    import sip_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [22:0] {
        ST_IDLE     = 23'h000001,
        ST_T_A      = 23'h000002,
        ST_T_B      = 23'h000004,
        ST_T_C      = 23'h000008,
        ST_S_INIT   = 23'h000010,
        ST_L_D      = 23'h000020,
        ST_L_E      = 23'h000040,
        ST_L_CMP    = 23'h000080,
        ST_L_FIN    = 23'h000100,
        ST_R_CHK    = 23'h000200,
        ST_R_D      = 23'h000400,
        ST_R_E      = 23'h000800,
        ST_R_CMP    = 23'h001000,
        ST_R_FIN    = 23'h002000,
        ST_N_P      = 23'h004000,
        ST_N_BR     = 23'h008000,
        ST_N_LFIN   = 23'h010000,
        ST_N_BL     = 23'h020000,
        ST_N_BLD    = 23'h040000,
        ST_N_RFIN   = 23'h080000,
        ST_SRCH_ISS = 23'h100000,
        ST_SRCH_CMP = 23'h200000,
        ST_DONE     = 23'h400000
    } state_t;

    localparam ix_t  IX_ONE   = ix_t'(1);
    localparam ix_t  IX_ZERO  = ix_t'(0);
    localparam val_t VAL_ONE  = val_t'(1);
    localparam val_t VAL_ZERO = val_t'(0);

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [CNT_W-1:0]   pc_reg, pc_next;
    logic signed [10:0] lz_reg, lz_next;
    logic [10:0]        rz_reg, rz_next;
    logic               rz_valid_reg, rz_valid_next;

    ix_t                idx_reg, idx_next;
    ix_t                bl_reg, bl_next;
    ix_t                br_reg, br_next;
    ix_t                lls_reg, lls_next;
    ix_t                lrs_reg, lrs_next;
    logic [BEST_W-1:0]  best_reg, best_next;
    ix_t                nl_reg, nl_next;
    ix_t                nr_reg, nr_next;
    logic signed [10:0] nll_reg, nll_next;
    logic signed [10:0] nlr_reg, nlr_next;
    logic               keep_reg, keep_next;
    logic [SC_W-1:0]    a_reg, a_next;
    val_t               d_reg, d_next;
    val_t               p_reg, p_next;
    val_t               ext_reg, ext_next;
    val_t               mlv_reg, mlv_next;
    val_t               sd_reg, sd_next;

    // Search unit state
    ix_t                lo_reg, lo_next;
    ix_t                cnt_reg, cnt_next;
    ix_t                step_reg, step_next;
    val_t               v_reg, v_next;
    logic               upper_reg, upper_next;

    ix_t                rd_idx;
    logic               rd_ok_reg;
    val_t               pos_v;
    logic [SC_W-1:0]    sc_l, sc_r;
    val_t               sum_v;
    ix_t                rz_eff;
    ix_t                lz_p1;
    logic               in_fire;

    function automatic logic ix_ok(input ix_t i);
        return !i[IX_W-1] && (int'(i) < TABLE_DEPTH);
    endfunction

    function automatic ix_t ix_max(input ix_t a, input ix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic ix_t ix_min(input ix_t a, input ix_t b);
        return (a < b) ? a : b;
    endfunction

    // Read data, zero outside the table
    assign pos_v  = rd_ok_reg ? val_t'(pos_rdata) : '0;
    assign sc_l   = rd_ok_reg ? sc_rdata[2*SC_W-1:SC_W] : '0;
    assign sc_r   = rd_ok_reg ? sc_rdata[SC_W-1:0] : '0;
    assign sum_v  = val_t'(sc_l) + val_t'(sc_r);
    assign rz_eff = rz_valid_reg ? ix_t'(rz_reg) : ix_t'(pc_reg);
    assign lz_p1  = ix_t'(lz_reg) + IX_ONE;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign mem_addr = AW'($unsigned(rd_idx));

    assign pos_wdata = in_item.position_value;
    assign sc_wdata  = {(in_item.left_score_in[SC_W-1]  ? {SC_W{1'b0}} : in_item.left_score_in),
                        (in_item.right_score_in[SC_W-1] ? {SC_W{1'b0}} : in_item.right_score_in)};

    assign res_valid          = (state_reg == ST_DONE);
    assign res.keep_interval  = keep_reg;
    assign res.new_left       = nl_reg[10:0];
    assign res.new_right      = nr_reg[11:0];
    assign res.new_last_left  = nll_reg;
    assign res.new_last_right = nlr_reg;

    // Sequencer and datapath
    always_comb begin
        ix_t  in_idx;
        ix_t  start;
        ix_t  stop;
        val_t sd;
        logic go_right;

        in_idx   = ix_t'(in_item.entry_index);
        start    = '0;
        stop     = '0;
        sd       = '0;
        go_right = 1'b0;

        state_next    = state_reg;
        ret_next      = ret_reg;
        gap_next      = gap_reg;
        pc_next       = pc_reg;
        lz_next       = lz_reg;
        rz_next       = rz_reg;
        rz_valid_next = rz_valid_reg;
        idx_next      = idx_reg;
        bl_next       = bl_reg;
        br_next       = br_reg;
        lls_next      = lls_reg;
        lrs_next      = lrs_reg;
        best_next     = best_reg;
        nl_next       = nl_reg;
        nr_next       = nr_reg;
        nll_next      = nll_reg;
        nlr_next      = nlr_reg;
        keep_next     = keep_reg;
        a_next        = a_reg;
        d_next        = d_reg;
        p_next        = p_reg;
        ext_next      = ext_reg;
        mlv_next      = mlv_reg;
        sd_next       = sd_reg;
        lo_next       = lo_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        v_next        = v_reg;
        upper_next    = upper_reg;
        rd_idx        = idx_reg;
        pos_we        = 1'b0;
        sc_we         = 1'b0;

        // Configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAP_ALLOWANCE:  gap_next = cfg_wdata[GAP_W-1:0];
                REG_POSITION_COUNT: pc_next  = cfg_wdata[CNT_W-1:0];
                default:            gap_next = gap_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                rd_idx = in_idx;
                if (in_fire) begin
                    idx_next  = in_idx;
                    bl_next   = ix_t'(in_item.bound_left);
                    br_next   = ix_t'(in_item.bound_right);
                    lls_next  = ix_t'(in_item.last_left_split);
                    lrs_next  = ix_t'(in_item.last_right_split);
                    best_next = in_item.best_score;
                    keep_next = 1'b0;
                    nl_next   = '0;
                    nr_next   = '0;
                    nll_next  = '0;
                    nlr_next  = '0;
                    sd = val_t'(in_item.score_gap) + val_t'(gap_reg);
                    sd_next = sd;
                    unique case (in_item.command)
                        CMD_LOAD: begin
                            pos_we = ix_ok(in_idx);
                        end
                        CMD_RECORD: begin
                            if (ix_ok(in_idx)) begin
                                sc_we = 1'b1;
                                if (in_item.left_score_in == '0 && ix_t'(lz_reg) < in_idx) begin
                                    lz_next = signed'(in_idx[10:0]);
                                end
                                if (in_item.right_score_in == '0 && in_idx < rz_eff) begin
                                    rz_next       = in_idx[10:0];
                                    rz_valid_next = 1'b1;
                                end
                            end
                        end
                        CMD_TEST:   state_next = ST_T_A;
                        CMD_SHRINK: state_next = ST_S_INIT;
                        CMD_NEIGH: begin
                            if (sd <= VAL_ZERO) begin
                                nl_next    = in_idx + IX_ONE;
                                nr_next    = in_idx;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_N_P;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            // Subinterval test: two reads of the score record
            ST_T_A: begin
                rd_idx     = lls_reg;
                state_next = ST_T_B;
            end
            ST_T_B: begin
                a_next     = sc_l;
                rd_idx     = lrs_reg;
                state_next = ST_T_C;
            end
            ST_T_C: begin
                keep_next  = (val_t'(a_reg) + val_t'(sc_r) + val_t'(gap_reg)) >= val_t'(best_reg);
                state_next = ST_DONE;
            end

            // Shrink: clamp to zero markers, then test the left split
            ST_S_INIT: begin
                nl_next  = ix_max(bl_reg, lz_p1);
                nr_next  = ix_min(br_reg, rz_eff - IX_ONE);
                nll_next = lls_reg[10:0];
                nlr_next = lrs_reg[10:0];
                if (!lls_reg[IX_W-1]) begin
                    rd_idx     = lls_reg;
                    state_next = ST_L_D;
                end else begin
                    state_next = ST_R_CHK;
                end
            end
            ST_L_D: begin
                d_next     = sum_v - val_t'(best_reg) + val_t'(gap_reg);
                p_next     = pos_v;
                state_next = ST_L_E;
            end
            ST_L_E: begin
                if (d_reg > VAL_ZERO) begin
                    ext_next   = p_reg + d_reg + VAL_ONE;
                    rd_idx     = nr_reg;
                    state_next = ST_L_CMP;
                end else begin
                    state_next = ST_R_CHK;
                end
            end
            ST_L_CMP: begin
                if (ext_reg <= pos_v) begin
                    lo_next    = nl_reg;
                    cnt_next   = nr_reg - nl_reg;
                    v_next     = ext_reg;
                    upper_next = 1'b0;
                    ret_next   = ST_L_FIN;
                    state_next = ST_SRCH_ISS;
                end else begin
                    nl_next    = IX_ONE;
                    nr_next    = '0;
                    nll_next   = '1;
                    nlr_next   = '1;
                    state_next = ST_DONE;
                end
            end
            ST_L_FIN: begin
                nl_next    = ix_max(nl_reg, lo_reg);
                state_next = ST_R_CHK;
            end

            // Shrink: test the right split
            ST_R_CHK: begin
                if (!lrs_reg[IX_W-1]) begin
                    rd_idx     = lrs_reg;
                    state_next = ST_R_D;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_R_D: begin
                d_next     = sum_v - val_t'(best_reg) + val_t'(gap_reg);
                p_next     = pos_v;
                state_next = ST_R_E;
            end
            ST_R_E: begin
                if (d_reg > VAL_ZERO) begin
                    ext_next   = p_reg - d_reg - VAL_ONE;
                    rd_idx     = nl_reg;
                    state_next = ST_R_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_R_CMP: begin
                if (ext_reg >= pos_v) begin
                    lo_next    = nl_reg;
                    cnt_next   = nr_reg - nl_reg;
                    v_next     = ext_reg;
                    upper_next = 1'b1;
                    ret_next   = ST_R_FIN;
                    state_next = ST_SRCH_ISS;
                end else begin
                    nl_next    = IX_ONE;
                    nr_next    = '0;
                    nll_next   = '1;
                    nlr_next   = '1;
                    state_next = ST_DONE;
                end
            end
            ST_R_FIN: begin
                nr_next    = ix_min(nr_reg, lo_reg);
                state_next = ST_DONE;
            end

            // Neighbourhood prune: right reach, then left reach
            ST_N_P: begin
                ext_next   = pos_v + sd_reg + VAL_ONE;
                mlv_next   = pos_v - sd_reg - VAL_ONE;
                rd_idx     = br_reg;
                state_next = ST_N_BR;
            end
            ST_N_BR: begin
                start = ix_max(idx_reg + IX_ONE, lz_p1);
                if (ext_reg < pos_v) begin
                    lo_next    = start;
                    cnt_next   = br_reg - start;
                    v_next     = ext_reg;
                    upper_next = 1'b0;
                    ret_next   = ST_N_LFIN;
                    state_next = ST_SRCH_ISS;
                end else begin
                    nl_next    = br_reg + IX_ONE;
                    state_next = ST_N_BL;
                end
            end
            ST_N_LFIN: begin
                nl_next    = lo_reg;
                state_next = ST_N_BL;
            end
            ST_N_BL: begin
                if (nl_reg[IX_W-1]) begin
                    nl_next = '0;
                end
                rd_idx     = bl_reg;
                state_next = ST_N_BLD;
            end
            ST_N_BLD: begin
                stop = ix_min(idx_reg - IX_ONE, rz_eff - IX_ONE);
                if (mlv_reg > pos_v) begin
                    lo_next    = bl_reg;
                    cnt_next   = stop - bl_reg;
                    v_next     = mlv_reg;
                    upper_next = 1'b1;
                    ret_next   = ST_N_RFIN;
                    state_next = ST_SRCH_ISS;
                end else begin
                    nr_next    = bl_reg - IX_ONE;
                    state_next = ST_DONE;
                end
            end
            ST_N_RFIN: begin
                nr_next    = lo_reg;
                state_next = ST_DONE;
            end

            // Binary search: probe the midpoint, then halve the range
            ST_SRCH_ISS: begin
                if (cnt_reg > IX_ZERO) begin
                    step_next  = cnt_reg >>> 1;
                    rd_idx     = lo_reg + (cnt_reg >>> 1);
                    state_next = ST_SRCH_CMP;
                end else begin
                    state_next = ret_reg;
                end
            end
            ST_SRCH_CMP: begin
                go_right = upper_reg ? (pos_v <= v_reg) : (pos_v < v_reg);
                if (go_right) begin
                    lo_next  = lo_reg + step_reg + IX_ONE;
                    cnt_next = cnt_reg - step_reg - IX_ONE;
                end else begin
                    cnt_next = step_reg;
                end
                state_next = ST_SRCH_ISS;
            end

            // Hold the result until the output register takes it
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            gap_reg      <= '0;
            pc_reg       <= '0;
            lz_reg       <= '1;
            rz_reg       <= '0;
            rz_valid_reg <= 1'b0;
            rd_ok_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            gap_reg      <= gap_next;
            pc_reg       <= pc_next;
            lz_reg       <= lz_next;
            rz_reg       <= rz_next;
            rz_valid_reg <= rz_valid_next;
            rd_ok_reg    <= ix_ok(rd_idx);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        bl_reg    <= bl_next;
        br_reg    <= br_next;
        lls_reg   <= lls_next;
        lrs_reg   <= lrs_next;
        best_reg  <= best_next;
        nl_reg    <= nl_next;
        nr_reg    <= nr_next;
        nll_reg   <= nll_next;
        nlr_reg   <= nlr_next;
        keep_reg  <= keep_next;
        a_reg     <= a_next;
        d_reg     <= d_next;
        p_reg     <= p_next;
        ext_reg   <= ext_next;
        mlv_reg   <= mlv_next;
        sd_reg    <= sd_next;
        lo_reg    <= lo_next;
        cnt_reg   <= cnt_next;
        step_reg  <= step_next;
        v_reg     <= v_next;
        upper_reg <= upper_next;
    end

    // A probe is only taken on a non-empty range
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SRCH_CMP |-> $past(cnt_reg) > IX_ZERO)
        else $error("search probe on empty range");

    // Table writes happen only in the accept cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_we || sc_we) |-> in_fire)
        else $error("table write outside accept");

    // Load and record finish in their accept cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (in_item.command == CMD_LOAD || in_item.command == CMD_RECORD)
        |=> state_reg == ST_IDLE)
        else $error("load or record left idle");

    // Once a right zero is seen the marker stays owned by records
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(rz_valid_reg))
        else $error("right zero marker lost");

endmodule

// File: rtl/split_interval_pruner_core.sv
// Top level: stream ports, output register, tables and sequencer.
// Load and record finish in their accept cycle; the block is ready again the next cycle.
// Subinterval test: reads in ST_T_A and ST_T_B, decision in ST_T_C, then ST_DONE feeds the output register.
// Shrink: clamp, then up to two binary searches, each probe passing ST_SRCH_ISS and
// ST_SRCH_CMP; neighbourhood prune runs up to two such searches as well.
// Next word accepted the cycle after the result moves out; reset keeps the tables.
module split_interval_pruner_core #(
    parameter int TABLE_DEPTH = sip_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // entry_index, position_value, left_score_in, right_score_in, bound_left,
    // bound_right, last_left_split, last_right_split, best_score, score_gap
    input  logic [143:0]               s_tdata,
    // command
    input  logic [2:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // keep_interval, new_left, new_right, new_last_left, new_last_right
    output logic [47:0]                m_tdata,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [sip_pkg::CFG_W-1:0]  cfg_wdata
);
    import sip_pkg::*;

    item_t                        item;
    res_t                         res;
    res_t                         out_reg;
    logic                         out_valid_reg;
    logic                         res_valid;
    logic                         res_ready;
    logic [$clog2(TABLE_DEPTH)-1:0] mem_addr;
    logic                         pos_we;
    logic                         sc_we;
    logic [POS_W-1:0]             pos_wdata;
    logic [POS_W-1:0]             pos_rdata;
    logic [2*SC_W-1:0]            sc_wdata;
    logic [2*SC_W-1:0]            sc_rdata;

    // Unpack the input word
    assign item.command          = s_tuser;
    assign item.entry_index      = s_tdata[9:0];
    assign item.position_value   = s_tdata[29:10];
    assign item.left_score_in    = s_tdata[46:30];
    assign item.right_score_in   = s_tdata[63:47];
    assign item.bound_left       = s_tdata[74:64];
    assign item.bound_right      = s_tdata[85:75];
    assign item.last_left_split  = s_tdata[96:86];
    assign item.last_right_split = s_tdata[107:97];
    assign item.best_score       = s_tdata[124:108];
    assign item.score_gap        = s_tdata[142:125];

    sip_tables #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_tables (
        .aclk      (aclk),
        .addr      (mem_addr),
        .pos_we    (pos_we),
        .pos_wdata (pos_wdata),
        .sc_we     (sc_we),
        .sc_wdata  (sc_wdata),
        .pos_rdata (pos_rdata),
        .sc_rdata  (sc_rdata)
    );

    sip_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_addr  (mem_addr),
        .pos_we    (pos_we),
        .pos_wdata (pos_wdata),
        .sc_we     (sc_we),
        .sc_wdata  (sc_wdata),
        .pos_rdata (pos_rdata),
        .sc_rdata  (sc_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    // Output register: load a finished word, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.new_last_right, out_reg.new_last_left,
                       out_reg.new_right, out_reg.new_left, out_reg.keep_interval};

endmodule

// File: sim/split_interval_pruner_core_tb.sv
// Self-checking testbench for split_interval_pruner_core: random stream traffic with a predictor.
module split_interval_pruner_core_tb;
    import sip_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 280;
    localparam int HOLD_CYCLES = 400;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [143:0]  s_tdata;
    logic [2:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [47:0]   m_tdata;
    logic          cfg_wr_en;
    logic          cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    split_interval_pruner_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Predictor state
    logic [POS_W-1:0] pos_tab [DEPTH];
    int   score_l [DEPTH];
    int   score_r [DEPTH];
    int   left_zero;
    int   right_zero;
    bit   right_zero_set;
    int   gap_reg;
    int   count_reg;

    item_t pending_q [$];
    res_t  result_q [$];
    item_t cur_word;
    int    errors;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    hold_req;
    bit    hold_done;
    int    hold_left;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int pos_of(int i);
        return (i >= 0 && i < DEPTH) ? int'(pos_tab[i]) : 0;
    endfunction

    function automatic int rz_now();
        return right_zero_set ? right_zero : count_reg;
    endfunction

    function automatic int ssum(int i);
        return (i >= 0 && i < DEPTH) ? score_l[i] + score_r[i] : 0;
    endfunction

    // Lower bound (upper=0) or upper bound (upper=1) over positions in [lo,hi)
    function automatic int bound_search(int lo, int hi, int v, bit upper);
        int cnt, stp, p;
        bit go;
        cnt = hi - lo;
        while (cnt > 0) begin
            stp = cnt / 2;
            p = pos_of(lo + stp);
            go = upper ? (p <= v) : (p < v);
            if (go) begin
                lo = lo + stp + 1;
                cnt -= stp + 1;
            end else begin
                cnt = stp;
            end
        end
        return lo;
    endfunction

    // Apply one accepted word; push the expected result where there is one
    task automatic prune_step(item_t it);
        int idx, ls, rs, bl, br, lls, lrs, best, sg, keep, nl, nr, nll, nlr;
        int a, b, d, ext, sd, p, start, stop;
        bit emptied;
        res_t r;
        idx = int'(it.entry_index);
        ls  = int'($signed(it.left_score_in));
        rs  = int'($signed(it.right_score_in));
        bl  = int'(it.bound_left);
        br  = int'($signed(it.bound_right));
        lls = int'($signed(it.last_left_split));
        lrs = int'($signed(it.last_right_split));
        best = int'(it.best_score);
        sg  = int'($signed(it.score_gap));
        keep = 0; nl = 0; nr = 0; nll = 0; nlr = 0;
        case (it.command)
            CMD_LOAD: begin
                pos_tab[idx] = it.position_value;
                return;
            end
            CMD_RECORD: begin
                if (ls == 0 && idx > left_zero) left_zero = idx;
                if (rs == 0 && idx < rz_now()) begin
                    right_zero = idx;
                    right_zero_set = 1'b1;
                end
                score_l[idx] = ls < 0 ? 0 : ls;
                score_r[idx] = rs < 0 ? 0 : rs;
                return;
            end
            CMD_TEST: begin
                a = (lls >= 0) ? score_l[lls] : 0;
                b = (lrs >= 0) ? score_r[lrs] : 0;
                keep = (a + b + gap_reg >= best) ? 1 : 0;
            end
            CMD_SHRINK: begin
                emptied = 1'b0;
                nl = (bl > left_zero + 1) ? bl : left_zero + 1;
                nr = (br < rz_now() - 1) ? br : rz_now() - 1;
                nll = lls;
                nlr = lrs;
                if (lls >= 0) begin
                    d = ssum(lls) - best + gap_reg;
                    if (d > 0) begin
                        ext = pos_of(lls) + d + 1;
                        if (ext <= pos_of(nr)) begin
                            a = bound_search(nl, nr, ext, 1'b0);
                            if (a > nl) nl = a;
                        end else begin
                            emptied = 1'b1;
                        end
                    end
                end
                if (!emptied && lrs >= 0) begin
                    d = ssum(lrs) - best + gap_reg;
                    if (d > 0) begin
                        ext = pos_of(lrs) - d - 1;
                        if (ext >= pos_of(nl)) begin
                            a = bound_search(nl, nr, ext, 1'b1);
                            if (a < nr) nr = a;
                        end else begin
                            emptied = 1'b1;
                        end
                    end
                end
                if (emptied) begin
                    nl = 1; nr = 0; nll = -1; nlr = -1;
                end
            end
            CMD_NEIGH: begin
                sd = sg + gap_reg;
                if (sd <= 0) begin
                    nl = idx + 1;
                    nr = idx;
                end else begin
                    p = pos_of(idx);
                    start = (idx + 1 > left_zero + 1) ? idx + 1 : left_zero + 1;
                    stop  = (idx - 1 < rz_now() - 1) ? idx - 1 : rz_now() - 1;
                    if (p + sd + 1 < pos_of(br)) nl = bound_search(start, br, p + sd + 1, 1'b0);
                    else nl = br + 1;
                    if (p - sd - 1 > pos_of(bl)) nr = bound_search(bl, stop, p - sd - 1, 1'b1);
                    else nr = bl - 1;
                    if (nl < 0) nl = 0;
                end
            end
            default: return;
        endcase
        r.keep_interval  = keep[0];
        r.new_left       = nl[10:0];
        r.new_right      = nr[11:0];
        r.new_last_left  = nll[10:0];
        r.new_last_right = nlr[10:0];
        result_q.push_back(r);
    endtask

    function automatic logic [143:0] pack_word(item_t it);
        return {1'b0, it.score_gap, it.best_score, it.last_right_split, it.last_left_split,
                it.bound_right, it.bound_left, it.right_score_in, it.left_score_in,
                it.position_value, it.entry_index};
    endfunction

    function automatic logic [16:0] pick_score();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5) return -17'sd1;
        if (k < 9) return 17'd0;
        if (k < 13) return 17'($urandom_range(65536, 131070));
        return 17'($urandom_range(1, 65535));
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Mostly well-formed words with random content, some pure noise
    function automatic item_t random_word();
        item_t it;
        int k, i, lo, hi;
        it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(0, 99);
        if (k < 10) it.command = CMD_LOAD;
        else if (k < 25) it.command = CMD_RECORD;
        else if (k < 45) it.command = CMD_TEST;
        else if (k < 70) it.command = CMD_SHRINK;
        else if (k < 95) it.command = CMD_NEIGH;
        else it.command = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 99) < 15) return it;
        i = int'(it.entry_index);
        case (it.command)
            CMD_LOAD: begin
                lo = (i > 0) ? int'(pos_tab[i-1]) : 0;
                hi = (i < DEPTH - 1) ? int'(pos_tab[i+1]) : 20'hFFFFF;
                if (lo <= hi && $urandom_range(0, 4) != 0)
                    it.position_value = 20'($urandom_range(lo, hi));
            end
            CMD_RECORD: begin
                it.left_score_in  = pick_score();
                it.right_score_in = pick_score();
            end
            CMD_TEST: begin
                it.last_left_split  = 11'(int'($urandom_range(0, 1024)) - 1);
                it.last_right_split = 11'(int'($urandom_range(0, 1024)) - 1);
                it.best_score = 17'($urandom_range(0, 140000));
            end
            CMD_SHRINK: begin
                lo = $urandom_range(0, 1023);
                hi = clip(lo + int'($urandom_range(0, 200)), 0, 1023);
                it.bound_left  = 11'(lo);
                it.bound_right = 11'(hi);
                it.last_left_split  = ($urandom_range(0, 3) == 0) ? -11'sd1 : 11'(clip(lo-1, -1, 1023));
                it.last_right_split = ($urandom_range(0, 3) == 0 || hi == 1023) ?
                                      -11'sd1 : 11'(hi + 1);
                it.best_score = 17'($urandom_range(0, 140000));
            end
            CMD_NEIGH: begin
                it.bound_left  = 11'(clip(i - int'($urandom_range(0, 300)), 0, 1023));
                it.bound_right = 11'(clip(i + int'($urandom_range(0, 300)), 0, 1023));
                if ($urandom_range(0, 1)) it.score_gap = 18'(int'($urandom_range(0, 3000)) - 800);
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic item_t blank_word(logic [2:0] cmd);
        item_t it;
        it = '0;
        it.command = cmd;
        it.last_left_split  = -11'sd1;
        it.last_right_split = -11'sd1;
        return it;
    endfunction

    // Feed the stream: hold a word until it is taken, then pick the next or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) prune_step(cur_word);
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_word = pending_q.pop_front();
                    s_tdata  <= pack_word(cur_word);
                    s_tuser  <= cur_word.command;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.keep_interval  = m_tdata[0];
            got.new_left       = m_tdata[11:1];
            got.new_right      = m_tdata[23:12];
            got.new_last_left  = m_tdata[34:24];
            got.new_last_right = m_tdata[45:35];
            if (result_q.size() == 0) begin
                report("unexpected result word", int'(m_tdata[45:0]), 0);
            end else begin
                want = result_q.pop_front();
                if (got.keep_interval != want.keep_interval)
                    report("keep_interval", got.keep_interval, want.keep_interval);
                if (got.new_left != want.new_left)
                    report("new_left", got.new_left, want.new_left);
                if (got.new_right != want.new_right)
                    report("new_right", got.new_right, want.new_right);
                if (got.new_last_left != want.new_last_left)
                    report("new_last_left", got.new_last_left, want.new_last_left);
                if (got.new_last_right != want.new_last_right)
                    report("new_last_right", got.new_last_right, want.new_last_right);
            end
        end
        m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || result_q.size() > 0 || s_tvalid) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        if (idx == REG_GAP_ALLOWANCE) gap_reg = val & 16'hFFFF;
        else count_reg = val & 11'h7FF;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        item_t it;
        int p;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
        hold_req = 1'b0; hold_done = 1'b0; hold_left = 0;
        cycles = 0; errors = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        left_zero = -1; right_zero = 0; right_zero_set = 1'b0;
        gap_reg = 0; count_reg = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words that touch no table entry, at reset settings
        pending_q.push_back(blank_word(3'd5));
        pending_q.push_back(blank_word(3'd6));
        pending_q.push_back(blank_word(3'd7));
        it = blank_word(CMD_TEST);
        pending_q.push_back(it);
        it.best_score = 17'h1FFFF;
        pending_q.push_back(it);
        it = blank_word(CMD_SHRINK);
        it.bound_right = 11'sd1023;
        it.last_right_split = -11'sd5;
        pending_q.push_back(it);
        it.bound_left = 11'd1024;
        it.bound_right = -11'sd1024;
        it.last_left_split = -11'sd1024;
        pending_q.push_back(it);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(REG_GAP_ALLOWANCE, 0); write_reg(REG_POSITION_COUNT, 1024); end
                1: begin write_reg(REG_GAP_ALLOWANCE, 65535); write_reg(REG_POSITION_COUNT, 0); end
                2: begin
                    write_reg(REG_GAP_ALLOWANCE, $urandom_range(0, 65535));
                    write_reg(REG_POSITION_COUNT, $urandom_range(0, 1024));
                end
                3: begin
                    write_reg(REG_GAP_ALLOWANCE, $urandom_range(0, 300));
                    write_reg(REG_POSITION_COUNT, 512);
                end
                default: begin
                    write_reg(REG_GAP_ALLOWANCE, 0); write_reg(REG_POSITION_COUNT, 1024);
                end
            endcase
            send_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 20 : 0;
            recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 20 : 0;
            if (ph == 0) begin
                // Fill both tables in ascending order, nonzero scores
                p = $urandom_range(0, 500);
                for (int i = 0; i < DEPTH; i++) begin
                    it = blank_word(CMD_LOAD);
                    it.entry_index = 10'(i);
                    it.position_value = (i == DEPTH - 1) ? 20'hFFFFF : 20'(p);
                    pending_q.push_back(it);
                    p += $urandom_range(0, 900);
                    it = blank_word(CMD_RECORD);
                    it.entry_index = 10'(i);
                    it.left_score_in  = 17'($urandom_range(1, 65535));
                    it.right_score_in = 17'($urandom_range(1, 65535));
                    pending_q.push_back(it);
                end
                // Directed corners over the filled table
                it = blank_word(CMD_NEIGH);
                it.entry_index = 10'd500; it.bound_left = 11'd400; it.bound_right = 11'sd600;
                it.score_gap = -18'sd131072;
                pending_q.push_back(it);
                it.score_gap = 18'sd131071;
                pending_q.push_back(it);
                it.entry_index = 10'd0; it.bound_left = 11'd0; it.bound_right = -11'sd1024;
                pending_q.push_back(it);
                it.entry_index = 10'd1023; it.bound_left = 11'd1024; it.bound_right = 11'sd1023;
                it.score_gap = 18'sd50;
                pending_q.push_back(it);
                it = blank_word(CMD_TEST);
                it.last_left_split = 11'sd1023; it.last_right_split = 11'sd0;
                it.best_score = 17'd65536;
                pending_q.push_back(it);
                it = blank_word(CMD_SHRINK);
                it.bound_left = 11'd10; it.bound_right = 11'sd20;
                it.last_left_split = 11'sd9; it.last_right_split = 11'sd21;
                pending_q.push_back(it);
                it.best_score = 17'h1FFFF;
                pending_q.push_back(it);
                it = blank_word(CMD_RECORD);
                it.entry_index = 10'd700;
                it.left_score_in = -17'sd1; it.right_score_in = -17'sd65536;
                pending_q.push_back(it);
                it.entry_index = 10'd3;
                it.left_score_in = 17'd0; it.right_score_in = 17'd65535;
                pending_q.push_back(it);
                it.entry_index = 10'd1000;
                it.left_score_in = 17'd65535; it.right_score_in = 17'd0;
                pending_q.push_back(it);
                it = blank_word(CMD_LOAD);
                it.entry_index = 10'd0;
                pending_q.push_back(it);
            end
            if (ph == 4) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) pending_q.push_back(random_word());
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
